/* rtl/htw_pkg.sv */
// package: shared constants and types for the hashed timer wheel
`timescale 1ns / 1ps
package htw_pkg;
	localparam int NUM_TIMERS_DEF   = 32;
	localparam int HASH_BUCKETS_DEF = 8;
	localparam int NUM_QUEUES_DEF   = 16;
	localparam int MAX_RESULTS      = 32;

	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_ALLOC = 3'd1;
	localparam logic [2:0] MODE_ARM   = 3'd2;
	localparam logic [2:0] MODE_FREE  = 3'd3;
	localparam logic [2:0] MODE_BIND  = 3'd4;

	localparam logic [1:0] KIND_EXPIRY  = 2'd0;
	localparam logic [1:0] KIND_GRANT   = 2'd1;
	localparam logic [1:0] KIND_FAIL    = 2'd2;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  timer_id;
		logic [31:0] token;
		logic [3:0]  queue_id;
		logic        last;
	} res_t;
endpackage

/* rtl/hashed_timer_wheel.sv */
// top level: hashed timer wheel with stream ports
// usage: send command beats on s_axis; mode 0 tick, 1 allocate, 2 arm, 3 free, 4 bind.
// allocate returns one beat (grant or fail); a tick returns one beat per expired
// timer in deadline order with tlast on the final one; other commands return none.
// s_axis_tdata bits from low: mode, timer_id, delay, token, queue_id.
// m_axis_tdata bits from low: kind, timer_id_res, token_res, queue_id_res; tlast = last.
// one command is taken at a time; s_axis_tready rises when its work is done and no result is pending.
// allocate scans the status table linearly; a tick walks its bucket one expired timer
// at a time; arm and free walk the bucket list through the timer memory (one read port,
// registered read), and a re-arm of a running timer walks both its old and new lists.
// a stalled m_axis holds the current beat and pauses the bucket walk.
// reset clears the tick count, marks every timer free and empties all buckets;
// token, queue, deadline and link memories need no clearing.
`timescale 1ns / 1ps
module hashed_timer_wheel #(
	parameter int NUM_TIMERS   = htw_pkg::NUM_TIMERS_DEF,
	parameter int HASH_BUCKETS = htw_pkg::HASH_BUCKETS_DEF,
	parameter int NUM_QUEUES   = htw_pkg::NUM_QUEUES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // mode, timer_id, delay, token, queue_id
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // kind, timer_id_res, token_res, queue_id_res
	output logic        m_axis_tlast
);
	htw_pkg::res_t res;

	htw_core #(.NUM_TIMERS(NUM_TIMERS), .HASH_BUCKETS(HASH_BUCKETS),
		.NUM_QUEUES(NUM_QUEUES)) u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.mode(s_axis_tdata[2:0]), .timer_id(s_axis_tdata[7:3]),
		.delay(s_axis_tdata[39:8]), .token(s_axis_tdata[71:40]),
		.queue_id(s_axis_tdata[75:72]),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {5'd0, res.queue_id, res.token, res.timer_id, res.kind};
	assign m_axis_tlast = res.last;
endmodule

/* rtl/htw_core.sv */
// core: timer memory, bucket heads and the list-walking sequencer
`timescale 1ns / 1ps
module htw_core #(
	parameter int NUM_TIMERS   = htw_pkg::NUM_TIMERS_DEF,
	parameter int HASH_BUCKETS = htw_pkg::HASH_BUCKETS_DEF,
	parameter int NUM_QUEUES   = htw_pkg::NUM_QUEUES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [4:0]         timer_id,
	input  logic [31:0]        delay,
	input  logic [31:0]        token,
	input  logic [3:0]         queue_id,
	output logic               res_valid,
	input  logic               res_ready,
	output htw_pkg::res_t      res
);
	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
	localparam int LW = IW + 1;
	localparam int CW = $clog2(htw_pkg::MAX_RESULTS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ALLOC = 4'd1;
	localparam logic [3:0] S_TREAD = 4'd2;
	localparam logic [3:0] S_TCHK = 4'd3;
	localparam logic [3:0] S_OUT = 4'd4;
	localparam logic [3:0] S_RREAD = 4'd5;
	localparam logic [3:0] S_RCHK = 4'd6;
	localparam logic [3:0] S_IREAD = 4'd7;
	localparam logic [3:0] S_ICHK = 4'd8;
	localparam logic [3:0] S_IWR = 4'd9;
	localparam logic [3:0] S_TEND = 4'd10;
	localparam logic [3:0] S_RBKT = 4'd11;

	// timer memory: deadline, link (null bit on top), token, queue
	logic [31:0]   dl_mem [NUM_TIMERS];
	logic [LW-1:0] lk_mem [NUM_TIMERS];
	logic [31:0]   tk_mem [NUM_TIMERS];
	logic [3:0]    qu_mem [NUM_TIMERS];
	logic [31:0]   rd_dl_q, rd_tk_q;
	logic [LW-1:0] rd_lk_q;
	logic [3:0]    rd_qu_q;

	logic [1:0]    status_q [NUM_TIMERS];
	logic [LW-1:0] head_q [HASH_BUCKETS];

	logic [3:0]    state_q;
	logic [31:0]   tick_q, dl_q;
	logic [IW-1:0] id_q, ai_q;
	logic [BW-1:0] b_q;
	logic [LW-1:0] cur_q, prev_q;
	logic [CW-1:0] n_q;
	logic          rm_q;
	htw_pkg::res_t res_q;
	logic          rv_q;

	logic          rd_en, wl_en, wd_en, wb_en;
	logic [IW-1:0] rd_a, wl_a, wd_a, wb_a;
	logic [LW-1:0] wl_d;
	logic [31:0]   wd_d, wb_tok;
	logic [3:0]    wb_q;

	logic          id_ok;
	logic          rm_go;
	logic [IW-1:0] in_id;
	logic [31:0]   tick_nx;

	assign in_id = IW'(timer_id);
	assign id_ok = {27'd0, timer_id} < 32'(NUM_TIMERS);
	assign rm_go = in_valid && in_ready && id_ok && status_q[in_id] == htw_pkg::ST_RUN
		&& (mode == htw_pkg::MODE_ARM || mode == htw_pkg::MODE_FREE);
	assign tick_nx = tick_q + 32'd1;
	assign in_ready = (state_q == S_IDLE) && !rv_q;
	assign res_valid = rv_q;
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_dl_q <= dl_mem[rd_a];
			rd_lk_q <= lk_mem[rd_a];
			rd_tk_q <= tk_mem[rd_a];
			rd_qu_q <= qu_mem[rd_a];
		end
		if (wl_en) lk_mem[wl_a] <= wl_d;
		if (wd_en) dl_mem[wd_a] <= wd_d;
		if (wb_en) begin
			tk_mem[wb_a] <= wb_tok;
			qu_mem[wb_a] <= wb_q;
		end
	end

	always_comb begin
		rd_en = 1'b0; rd_a = cur_q[IW-1:0];
		wl_en = 1'b0; wl_a = prev_q[IW-1:0]; wl_d = '0;
		wd_en = 1'b0; wd_a = in_id; wd_d = tick_q + delay;
		wb_en = 1'b0; wb_a = in_id; wb_tok = token; wb_q = queue_id;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready && mode == htw_pkg::MODE_BIND && id_ok
						&& {28'd0, queue_id} < 32'(NUM_QUEUES))
					wb_en = 1'b1;
				// fetch the stored deadline of a running timer to find its bucket
				if (rm_go) begin
					rd_en = 1'b1; rd_a = in_id;
				end
			end
			S_TREAD, S_RREAD, S_IREAD: rd_en = !cur_q[LW-1];
			S_RCHK: begin
				if (cur_q[IW-1:0] == id_q && !prev_q[LW-1]) begin
					wl_en = 1'b1; wl_d = rd_lk_q;
				end
			end
			S_IWR: begin
				wl_en = 1'b1; wl_a = id_q; wl_d = cur_q;
			end
			S_TEND: begin
				if (!prev_q[LW-1]) begin
					wl_en = 1'b1; wl_d = {1'b0, id_q};
				end
				wd_en = 1'b1; wd_a = id_q; wd_d = dl_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tick_q <= '0;
			rv_q <= 1'b0;
			n_q <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) status_q[i] <= htw_pkg::ST_FREE;
			for (int i = 0; i < HASH_BUCKETS; i++) head_q[i] <= {1'b1, {IW{1'b0}}};
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rv_q && res_ready) rv_q <= 1'b0;
					if (in_valid && in_ready) begin
						id_q <= in_id;
						dl_q <= tick_q + delay;
						n_q <= '0;
						case (mode)
							htw_pkg::MODE_TICK: begin
								tick_q <= tick_nx;
								b_q <= BW'(tick_nx % HASH_BUCKETS);
								cur_q <= head_q[BW'(tick_nx % HASH_BUCKETS)];
								state_q <= S_TREAD;
							end
							htw_pkg::MODE_ALLOC: begin
								ai_q <= '0;
								state_q <= S_ALLOC;
							end
							htw_pkg::MODE_ARM: begin
								if (id_ok && status_q[in_id] != htw_pkg::ST_FREE) begin
									rm_q <= 1'b0;
									cur_q <= {1'b1, {IW{1'b0}}};
									if (status_q[in_id] == htw_pkg::ST_RUN) begin
										state_q <= S_RBKT;
									end else begin
										b_q <= BW'((tick_q + delay) % HASH_BUCKETS);
										state_q <= S_IREAD;
									end
									status_q[in_id] <= htw_pkg::ST_RUN;
								end
							end
							htw_pkg::MODE_FREE: begin
								if (id_ok) begin
									rm_q <= 1'b1;
									cur_q <= {1'b1, {IW{1'b0}}};
									if (status_q[in_id] == htw_pkg::ST_RUN) begin
										state_q <= S_RBKT;
									end
									status_q[in_id] <= htw_pkg::ST_FREE;
								end
							end
							default: ;
						endcase
						prev_q <= {1'b1, {IW{1'b0}}};
					end
				end
				S_RBKT: begin
					b_q <= BW'(rd_dl_q % HASH_BUCKETS);
					state_q <= S_RREAD;
				end
				S_ALLOC: begin
					if (status_q[ai_q] == htw_pkg::ST_FREE) begin
						status_q[ai_q] <= htw_pkg::ST_ALLOC;
						res_q <= '{htw_pkg::KIND_GRANT, 5'(ai_q), 32'd0, 4'd0, 1'b1};
						rv_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (32'(ai_q) == NUM_TIMERS - 1) begin
						res_q <= '{htw_pkg::KIND_FAIL, 5'd0, 32'd0, 4'd0, 1'b1};
						rv_q <= 1'b1;
						state_q <= S_IDLE;
					end else ai_q <= ai_q + IW'(1);
				end
				S_TREAD: begin
					if (cur_q[LW-1]) begin
						head_q[b_q] <= cur_q;
						if (n_q != '0) begin
							res_q.last <= 1'b1;
							rv_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end else state_q <= S_TCHK;
				end
				S_TCHK: begin
					if (rd_dl_q <= tick_q && 32'(n_q) < htw_pkg::MAX_RESULTS) begin
						if (n_q != '0) begin
							rv_q <= 1'b1;
						end
						state_q <= S_OUT;
					end else begin
						head_q[b_q] <= cur_q;
						if (n_q != '0) begin
							res_q.last <= 1'b1;
							rv_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (!rv_q || res_ready) begin
						rv_q <= 1'b0;
						res_q <= '{htw_pkg::KIND_EXPIRY, 5'(cur_q[IW-1:0]), rd_tk_q,
							rd_qu_q, 1'b0};
						status_q[cur_q[IW-1:0]] <= htw_pkg::ST_ALLOC;
						n_q <= n_q + CW'(1);
						cur_q <= rd_lk_q;
						state_q <= S_TREAD;
					end
				end
				S_RREAD: begin
					if (cur_q == {1'b1, {IW{1'b0}}} && prev_q == {1'b1, {IW{1'b0}}}) begin
						cur_q <= head_q[b_q];
						state_q <= S_RREAD;
						prev_q <= {1'b1, {IW{1'b1}}};
					end else if (cur_q[LW-1]) state_q <= S_IDLE;
					else state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (cur_q[IW-1:0] == id_q) begin
						if (prev_q[LW-1]) head_q[b_q] <= rd_lk_q;
						if (rm_q) state_q <= S_IDLE;
						else begin
							b_q <= BW'(dl_q % HASH_BUCKETS);
							cur_q <= {1'b1, {IW{1'b0}}};
							prev_q <= {1'b1, {IW{1'b0}}};
							state_q <= S_IREAD;
						end
					end else begin
						prev_q <= cur_q;
						cur_q <= rd_lk_q;
						state_q <= S_RREAD;
					end
				end
				S_IREAD: begin
					if (cur_q == {1'b1, {IW{1'b0}}} && prev_q == {1'b1, {IW{1'b0}}}) begin
						cur_q <= head_q[b_q];
						prev_q <= {1'b1, {IW{1'b1}}};
					end else if (cur_q[LW-1]) state_q <= S_IWR;
					else state_q <= S_ICHK;
				end
				S_ICHK: begin
					if (rd_dl_q <= dl_q) begin
						prev_q <= cur_q;
						cur_q <= rd_lk_q;
						state_q <= S_IREAD;
					end else state_q <= S_IWR;
				end
				S_IWR: begin
					if (prev_q[LW-1]) head_q[b_q] <= {1'b0, id_q};
					state_q <= S_TEND;
				end
				S_TEND: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_last_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && res_q.last) |-> (state_q == S_IDLE))
		else $error("last beat outside idle");
	ap_alloc_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |=> (state_q == S_ALLOC || state_q == S_IDLE))
		else $error("alloc exit");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && !res_ready) |=> (rv_q && $stable(res_q)))
		else $error("result dropped");
endmodule

/* verif/htw_checker.sv */
// checker: watches both streams of the timer wheel, predicts results and compares them
`timescale 1ns / 1ps
module htw_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // mode, timer_id, delay, token, queue_id
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,  // kind, timer_id_res, token_res, queue_id_res
	input  logic        m_axis_tlast,
	output int          fail_cnt,
	output int          pending,
	output int          expiry_cnt,
	output int          grant_cnt,
	output int          deny_cnt
);
	localparam int NT = htw_pkg::NUM_TIMERS_DEF;
	localparam int NB = htw_pkg::HASH_BUCKETS_DEF;

	logic [31:0]   ticks;
	logic [1:0]    tstat [NT];
	logic [31:0]   tdead [NT];
	logic [31:0]   ttok  [NT];
	logic [3:0]    tque  [NT];
	int            tnext [NT];
	int            bhead [NB];
	htw_pkg::res_t want_q [$];

	function automatic void unlink(int id);
		int b, prev, cur;
		b = int'(tdead[id] % NB);
		prev = -1;
		cur = bhead[b];
		for (int s = 0; s < NT && cur >= 0; s++) begin
			if (cur == id) begin
				if (prev < 0) bhead[b] = tnext[cur];
				else tnext[prev] = tnext[cur];
				return;
			end
			prev = cur;
			cur = tnext[cur];
		end
	endfunction

	function automatic void file_sorted(int id);
		int b, prev, cur, s;
		b = int'(tdead[id] % NB);
		prev = -1;
		cur = bhead[b];
		s = 0;
		while (s < NT && cur >= 0 && tdead[cur] <= tdead[id]) begin
			prev = cur;
			cur = tnext[cur];
			s++;
		end
		tnext[id] = cur;
		if (prev < 0) bhead[b] = id;
		else tnext[prev] = id;
	endfunction

	function automatic void predict(logic [79:0] d);
		logic [2:0]    mode;
		int            id, b, cur, n, idx;
		logic [31:0]   dly;
		htw_pkg::res_t r;
		mode = d[2:0];
		id = int'(d[7:3]);
		dly = d[39:8];
		n = 0;
		case (mode)
			htw_pkg::MODE_TICK: begin
				ticks = ticks + 32'd1;
				b = int'(ticks % NB);
				cur = bhead[b];
				while (n < htw_pkg::MAX_RESULTS && cur >= 0 && tdead[cur] <= ticks) begin
					r = '{htw_pkg::KIND_EXPIRY, cur[4:0], ttok[cur], tque[cur], 1'b0};
					want_q.push_back(r);
					tstat[cur] = htw_pkg::ST_ALLOC;
					cur = tnext[cur];
					n++;
				end
				bhead[b] = cur;
			end
			htw_pkg::MODE_ALLOC: begin
				idx = -1;
				for (int i = 0; i < NT; i++)
					if (idx < 0 && tstat[i] == htw_pkg::ST_FREE) idx = i;
				if (idx >= 0) begin
					tstat[idx] = htw_pkg::ST_ALLOC;
					r = '{htw_pkg::KIND_GRANT, idx[4:0], 32'd0, 4'd0, 1'b0};
				end else begin
					r = '{htw_pkg::KIND_FAIL, 5'd0, 32'd0, 4'd0, 1'b0};
				end
				want_q.push_back(r);
				n = 1;
			end
			htw_pkg::MODE_ARM: begin
				if (tstat[id] != htw_pkg::ST_FREE) begin
					if (tstat[id] == htw_pkg::ST_RUN) unlink(id);
					tdead[id] = ticks + dly;
					tstat[id] = htw_pkg::ST_RUN;
					file_sorted(id);
				end
			end
			htw_pkg::MODE_FREE: begin
				if (tstat[id] == htw_pkg::ST_RUN) unlink(id);
				tstat[id] = htw_pkg::ST_FREE;
			end
			htw_pkg::MODE_BIND: begin
				ttok[id] = d[71:40];
				tque[id] = d[75:72];
			end
			default: ;
		endcase
		if (n > 0) want_q[$].last = 1'b1;
	endfunction

	assign pending = want_q.size();

	always @(posedge clk or negedge arst_n) begin
		htw_pkg::res_t w;
		if (!arst_n) begin
			ticks = '0;
			for (int i = 0; i < NT; i++) begin
				tstat[i] = htw_pkg::ST_FREE;
				tdead[i] = '0;
				ttok[i] = '0;
				tque[i] = '0;
				tnext[i] = -1;
			end
			for (int i = 0; i < NB; i++) bhead[i] = -1;
			want_q.delete();
			fail_cnt <= 0;
			expiry_cnt <= 0;
			grant_cnt <= 0;
			deny_cnt <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (want_q.size() == 0) begin
					$error("unexpected result beat %h", m_axis_tdata);
					fail_cnt <= fail_cnt + 1;
				end else begin
					w = want_q.pop_front();
					if (m_axis_tdata[1:0] == htw_pkg::KIND_EXPIRY) expiry_cnt <= expiry_cnt + 1;
					if (m_axis_tdata[1:0] == htw_pkg::KIND_GRANT) grant_cnt <= grant_cnt + 1;
					if (m_axis_tdata[1:0] == htw_pkg::KIND_FAIL) deny_cnt <= deny_cnt + 1;
					if (m_axis_tdata[1:0] !== w.kind ||
					    m_axis_tdata[6:2] !== w.timer_id ||
					    m_axis_tdata[38:7] !== w.token ||
					    m_axis_tdata[42:39] !== w.queue_id ||
					    m_axis_tlast !== w.last) begin
						if (m_axis_tdata[1:0] !== w.kind)
							$error("kind: expected %0d, got %0d", w.kind, m_axis_tdata[1:0]);
						if (m_axis_tdata[6:2] !== w.timer_id)
							$error("timer_id_res: expected %0d, got %0d",
								w.timer_id, m_axis_tdata[6:2]);
						if (m_axis_tdata[38:7] !== w.token)
							$error("token_res: expected %h, got %h",
								w.token, m_axis_tdata[38:7]);
						if (m_axis_tdata[42:39] !== w.queue_id)
							$error("queue_id_res: expected %0d, got %0d",
								w.queue_id, m_axis_tdata[42:39]);
						if (m_axis_tlast !== w.last)
							$error("last: expected %0d, got %0d", w.last, m_axis_tlast);
						fail_cnt <= fail_cnt + 1;
					end
				end
			end
		end
	end
endmodule

/* verif/tb_top.sv */
// testbench top: command stimulus, result back-pressure and verdict for the timer wheel
`timescale 1ns / 1ps
module tb_top;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_cnt, pending, expiry_cnt, grant_cnt, deny_cnt;
	int          sent = 0;
	bit          hold_req = 1'b0;
	bit          no_gaps = 1'b0;
	bit          bound [32];

	always #5 clk = ~clk;

	hashed_timer_wheel u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	htw_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.fail_cnt(fail_cnt), .pending(pending), .expiry_cnt(expiry_cnt),
		.grant_cnt(grant_cnt), .deny_cnt(deny_cnt)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_gaps || r < 65) return 0;
		if (r < 94) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic send_cmd(logic [2:0] mode, int id, logic [31:0] dly,
	                        logic [31:0] tok, logic [3:0] q);
		int g;
		s_axis_tdata = {4'd0, q, tok, dly, id[4:0], mode};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent++;
		if (mode == htw_pkg::MODE_BIND) bound[id] = 1'b1;
		g = pick_gap();
		if (g > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_delay();
		int r;
		r = $urandom_range(99);
		if (r < 75) return $urandom_range(40);
		if (r < 85) return 32'hffffffff - $urandom_range(20);
		return $urandom();
	endfunction

	always @(negedge clk) begin
		int g;
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			for (int c = 0; c < 400; c++) @(negedge clk);
			hold_req = 1'b0;
		end else begin
			g = pick_gap();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				for (int c = 0; c < g - 1; c++) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int id, r;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: fill the pool, overflow it, then expire all of it on one tick
		for (int i = 0; i < 33; i++) send_cmd(htw_pkg::MODE_ALLOC, 0, '0, '0, '0);
		for (int i = 0; i < 32; i++)
			send_cmd(htw_pkg::MODE_BIND, i, '0, (i % 2) ? 32'hffffffff : 32'h0, i[3:0]);
		for (int i = 0; i < 32; i++) send_cmd(htw_pkg::MODE_ARM, i, 32'd8, '0, '0);
		for (int i = 0; i < 8; i++) send_cmd(htw_pkg::MODE_TICK, 0, '0, '0, '0);
		drain();
		send_cmd(htw_pkg::MODE_ARM, 3, 32'd0, '0, '0);
		send_cmd(htw_pkg::MODE_ARM, 4, 32'hffffffff, '0, '0);
		send_cmd(htw_pkg::MODE_ARM, 5, 32'd3, '0, '0);
		send_cmd(htw_pkg::MODE_ARM, 6, 32'd3, '0, '0);
		send_cmd(htw_pkg::MODE_ARM, 5, 32'd5, '0, '0);
		send_cmd(htw_pkg::MODE_FREE, 6, '0, '0, '0);
		send_cmd(htw_pkg::MODE_FREE, 6, '0, '0, '0);
		send_cmd(htw_pkg::MODE_ARM, 6, 32'd1, '0, '0);
		send_cmd(3'd7, 31, 32'hffffffff, 32'hffffffff, 4'hf);
		send_cmd(3'd5, 0, '0, '0, '0);
		send_cmd(htw_pkg::MODE_ALLOC, 0, '0, '0, '0);
		for (int i = 0; i < 9; i++) send_cmd(htw_pkg::MODE_TICK, 0, '0, '0, '0);
		drain();

		// random: mixed commands; armed timers are bound first, delays mostly short
		for (int n = 0; n < 80; n++) begin
			if (n == 20) hold_req = 1'b1;
			if (n == 45) drain();
			no_gaps = (n >= 55 && n < 70);
			r = $urandom_range(99);
			id = $urandom_range(31);
			if (r < 35)
				send_cmd(htw_pkg::MODE_TICK, id, $urandom(), $urandom(), 4'($urandom()));
			else if (r < 50)
				send_cmd(htw_pkg::MODE_ALLOC, id, $urandom(), $urandom(), 4'($urandom()));
			else if (r < 75) begin
				if (!bound[id])
					send_cmd(htw_pkg::MODE_BIND, id, $urandom(), $urandom(), 4'($urandom()));
				send_cmd(htw_pkg::MODE_ARM, id, pick_delay(), $urandom(), 4'($urandom()));
			end
			else if (r < 85)
				send_cmd(htw_pkg::MODE_FREE, id, $urandom(), $urandom(), 4'($urandom()));
			else if (r < 96)
				send_cmd(htw_pkg::MODE_BIND, id, $urandom(), $urandom(), 4'($urandom()));
			else send_cmd(3'($urandom_range(7, 5)), id, $urandom(), $urandom(),
				4'($urandom()));
		end
		no_gaps = 1'b0;
		for (int i = 0; i < 16; i++) send_cmd(htw_pkg::MODE_TICK, 0, '0, '0, '0);
		drain();
		repeat (200) @(negedge clk);
		$display("sent %0d commands: %0d expiries, %0d grants, %0d failed allocations",
			sent, expiry_cnt, grant_cnt, deny_cnt);
		if (fail_cnt == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* filelist.f */
rtl/htw_pkg.sv
rtl/htw_core.sv
rtl/hashed_timer_wheel.sv
verif/htw_checker.sv
verif/tb_top.sv
